// ===== sv/afs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afs_pkg
// Shared widths, command codes and control/status types for the
// allele f-statistics accumulator.
// ----------------------------------------------------------------------------
package afs_pkg;

    localparam int COUNT_BITS = 16;
    localparam int LOCUS_BITS = 24;
    localparam int FRAC_BITS  = 30;

    localparam int IN_W      = 16;
    localparam int NUM_POPS  = 4;
    localparam int IN_DATA_W = IN_W * 2 * (NUM_POPS + 1);
    localparam int VAL_W     = 32;
    localparam int OUT_DATA_W = VAL_W * 4;
    localparam int SUM_W     = 56;
    localparam int FREQ_W    = FRAC_BITS + 1;
    localparam int TOT_W     = COUNT_BITS + 1;
    localparam int MUL_W     = 32;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int DIV_W     = 2 * FRAC_BITS + 2;
    localparam int Q_W       = 32;
    localparam int WIDE_W    = DIV_W + Q_W;
    localparam int IDX_W     = 2;

    localparam logic [4:0] OP_NONE     = 5'd0;
    localparam logic [4:0] OP_LOAD     = 5'd1;
    localparam logic [4:0] OP_DIV_F0   = 5'd2;
    localparam logic [4:0] OP_DIV_F1   = 5'd3;
    localparam logic [4:0] OP_DIV_A1   = 5'd4;
    localparam logic [4:0] OP_DIV_H    = 5'd5;
    localparam logic [4:0] OP_DIV_FST  = 5'd6;
    localparam logic [4:0] OP_DIV_AVG  = 5'd7;
    localparam logic [4:0] OP_MUL      = 5'd8;
    localparam logic [4:0] OP_F2       = 5'd9;
    localparam logic [4:0] OP_F3       = 5'd10;
    localparam logic [4:0] OP_F4       = 5'd11;
    localparam logic [4:0] OP_N        = 5'd12;
    localparam logic [4:0] OP_D1       = 5'd13;
    localparam logic [4:0] OP_D2       = 5'd14;
    localparam logic [4:0] OP_ACC      = 5'd15;
    localparam logic [4:0] OP_OUT_LOC  = 5'd16;
    localparam logic [4:0] OP_OUT_AVG  = 5'd17;

    localparam logic [2:0] MS_H  = 3'd0;
    localparam logic [2:0] MS_X2 = 3'd1;
    localparam logic [2:0] MS_F3 = 3'd2;
    localparam logic [2:0] MS_F4 = 3'd3;
    localparam logic [2:0] MS_N  = 3'd4;
    localparam logic [2:0] MS_D1 = 3'd5;
    localparam logic [2:0] MS_D2 = 3'd6;

    typedef struct packed {
        logic [4:0]       op;
        logic [2:0]       mul_sel;
        logic [IDX_W-1:0] idx;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
        logic last;
    } stat_t;

endpackage

// ===== sv/afs_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afs_div
// Restoring divider, one quotient bit per cycle. Divides {hi, lo} by den,
// hi below den, giving a Q_W-bit quotient after Q_W iterations.
// ----------------------------------------------------------------------------
module afs_div
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [afs_pkg::DIV_W-1:0] hi,
    input  logic [afs_pkg::Q_W-1:0]   lo,
    input  logic [afs_pkg::DIV_W-1:0] den,
    output logic                      done,
    output logic [afs_pkg::Q_W-1:0]   quo
);

    import afs_pkg::*;

    localparam int CNT_W = $clog2(Q_W);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [DIV_W-1:0]   rem_reg;
    logic [DIV_W-1:0]   den_reg;
    logic [Q_W-1:0]     lo_reg;
    logic [Q_W-1:0]     q_reg;
    logic [DIV_W:0]     rem_shift;
    logic [DIV_W:0]     diff;
    logic [DIV_W-1:0]   rem_next;
    logic               qbit;

    always_comb
    begin
        rem_shift = {rem_reg, lo_reg[Q_W-1]};
        diff      = rem_shift - {1'b0, den_reg};
        qbit      = ~diff[DIV_W];
        rem_next  = qbit ? diff[DIV_W-1:0] : rem_shift[DIV_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(Q_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= hi;
            den_reg <= den;
            lo_reg  <= lo;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            lo_reg  <= {lo_reg[Q_W-2:0], 1'b0};
            q_reg   <= {q_reg[Q_W-2:0], qbit};
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

// ===== sv/afs_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afs_datapath
// Count registers, frequency and heterozygosity registers, shared multiplier
// and divider, running sums and the output register.
// ----------------------------------------------------------------------------
module afs_datapath
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  afs_pkg::cmd_t                  cmd,
    output afs_pkg::stat_t                 stat,
    input  logic [afs_pkg::IN_DATA_W-1:0]  in_data,
    input  logic                           in_last,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [afs_pkg::OUT_DATA_W-1:0] out_data,
    output logic                           out_kind,
    output logic                           out_last
);

    import afs_pkg::*;

    localparam logic signed [MUL_W-1:0] ONE = MUL_W'(1) << FRAC_BITS;
    localparam logic signed [VAL_W-1:0] VMAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VMIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam int HP_W = FREQ_W + 1;

    function automatic logic signed [VAL_W-1:0] rnd_sat(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] w;
        logic signed [PROD_W-1:0] s;
        w = v + (PROD_W'(1) << (FRAC_BITS - 1));
        s = w >>> FRAC_BITS;
        if (s > PROD_W'(VMAX))
            rnd_sat = VMAX;
        else if (s < PROD_W'(VMIN))
            rnd_sat = VMIN;
        else
            rnd_sat = s[VAL_W-1:0];
    endfunction

    function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] s,
                                                        input logic signed [VAL_W-1:0] v);
        logic signed [SUM_W:0] r;
        r = {s[SUM_W-1], s} + {{(SUM_W+1-VAL_W){v[VAL_W-1]}}, v};
        if (r[SUM_W] != r[SUM_W-1])
            sat_add = r[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        else
            sat_add = r[SUM_W-1:0];
    endfunction

    function automatic logic [WIDE_W-1:0] frac_num(input logic [DIV_W-1:0] n);
        frac_num = WIDE_W'(n) << (FRAC_BITS + 1);
    endfunction

    function automatic logic signed [PROD_W-1:0] hshift(input logic [FREQ_W-1:0] h);
        hshift = signed'(PROD_W'(h) << FRAC_BITS);
    endfunction

    logic [COUNT_BITS-1:0]      pa0_reg [NUM_POPS];
    logic [COUNT_BITS-1:0]      pa1_reg [NUM_POPS];
    logic [FREQ_W-1:0]          f0_reg  [NUM_POPS];
    logic [FREQ_W-1:0]          f1_reg  [NUM_POPS];
    logic [FREQ_W-1:0]          h_reg   [NUM_POPS];
    logic [FREQ_W-1:0]          a1r_reg;
    logic                       anc1_reg;
    logic                       last_reg;
    logic signed [MUL_W-1:0]    ma_reg;
    logic signed [MUL_W-1:0]    mb_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [VAL_W-1:0]    f2_reg;
    logic signed [VAL_W-1:0]    f3_reg;
    logic signed [VAL_W-1:0]    f4_reg;
    logic signed [VAL_W-1:0]    fst_reg;
    logic [DIV_W-1:0]           n_reg;
    logic [DIV_W-1:0]           d_reg;
    logic [4:0]                 dst_reg;
    logic                       ovf_reg;
    logic signed [SUM_W-1:0]    sum_reg [3];
    logic [LOCUS_BITS-1:0]      count_reg;
    logic signed [VAL_W-1:0]    avg_reg [3];
    logic                       out_valid_reg;
    logic [OUT_DATA_W-1:0]      out_data_reg;
    logic                       out_kind_reg;
    logic                       out_last_reg;

    logic [COUNT_BITS-1:0]      a0;
    logic [COUNT_BITS-1:0]      a1;
    logic [TOT_W-1:0]           tot;
    logic                       hzero;
    logic [FREQ_W-1:0]          anc [NUM_POPS];
    logic [FREQ_W-1:0]          der [NUM_POPS];
    logic signed [MUL_W-1:0]    anc_s [NUM_POPS];
    logic signed [MUL_W-1:0]    der_s [NUM_POPS];
    logic signed [MUL_W-1:0]    x_s;
    logic signed [MUL_W-1:0]    y_s;
    logic signed [MUL_W-1:0]    ma_next;
    logic signed [MUL_W-1:0]    mb_next;
    logic [PROD_W-1:0]          hsum;
    logic [HP_W-1:0]            hp;
    logic signed [SUM_W-1:0]    sum_sel;
    logic [SUM_W-1:0]           mag;
    logic [SUM_W:0]             avg_num;
    logic                       div_start;
    logic [WIDE_W-1:0]          wide;
    logic [DIV_W-1:0]           div_hi;
    logic [Q_W-1:0]             div_lo;
    logic [DIV_W-1:0]           div_den;
    logic                       div_done;
    logic [Q_W-1:0]             div_q;
    logic [Q_W:0]               qinc;
    logic [FREQ_W-1:0]          qr;
    logic signed [VAL_W-1:0]    avg_val;
    logic                       out_free;
    logic                       out_load;

    always_comb
    begin
        a0    = pa0_reg[cmd.idx];
        a1    = pa1_reg[cmd.idx];
        tot   = TOT_W'(a0) + TOT_W'(a1);
        hzero = (a0 == '0) || (a1 == '0);
        for (int k = 0; k < NUM_POPS; k++)
        begin
            anc[k]   = anc1_reg ? f1_reg[k] : f0_reg[k];
            der[k]   = anc1_reg ? f0_reg[k] : f1_reg[k];
            anc_s[k] = signed'(MUL_W'(anc[k]));
            der_s[k] = signed'(MUL_W'(der[k]));
        end
        x_s = anc_s[0] - anc_s[1];
        y_s = der_s[0] - der_s[1];
    end

    always_comb
    begin
        ma_next = ma_reg;
        mb_next = mb_reg;
        if (cmd.op == OP_MUL)
        begin
            case (cmd.mul_sel)
                MS_H:
                begin
                    ma_next = signed'(MUL_W'(f0_reg[cmd.idx]));
                    mb_next = signed'(MUL_W'(a1r_reg));
                end
                MS_X2:
                begin
                    ma_next = x_s;
                    mb_next = x_s;
                end
                MS_F3:
                begin
                    ma_next = anc_s[2] - anc_s[0];
                    mb_next = anc_s[2] - anc_s[1];
                end
                MS_F4:
                begin
                    ma_next = x_s;
                    mb_next = anc_s[2] - anc_s[3];
                end
                MS_N:
                begin
                    ma_next = y_s;
                    mb_next = y_s;
                end
                MS_D1:
                begin
                    ma_next = der_s[0];
                    mb_next = ONE - der_s[1];
                end
                MS_D2:
                begin
                    ma_next = der_s[1];
                    mb_next = ONE - der_s[0];
                end
                default:
                begin
                    ma_next = ma_reg;
                    mb_next = mb_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        hsum = prod_reg + (PROD_W'(1) << (FRAC_BITS - 1));
        hp   = hsum[FRAC_BITS +: HP_W];
        case (cmd.idx)
            2'd0:    sum_sel = sum_reg[0];
            2'd1:    sum_sel = sum_reg[1];
            default: sum_sel = sum_reg[2];
        endcase
        mag     = sum_sel[SUM_W-1] ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);
        avg_num = {1'b0, mag} + (SUM_W+1)'(count_reg >> 1);
    end

    always_comb
    begin
        div_start = 1'b0;
        wide      = '0;
        div_den   = '0;
        case (cmd.op)
            OP_DIV_F0:
            begin
                div_start = 1'b1;
                wide      = frac_num(DIV_W'(a0));
                div_den   = DIV_W'(tot);
            end
            OP_DIV_F1:
            begin
                div_start = 1'b1;
                wide      = frac_num(DIV_W'(a1));
                div_den   = DIV_W'(tot);
            end
            OP_DIV_A1:
            begin
                div_start = 1'b1;
                wide      = frac_num(DIV_W'(a1));
                div_den   = DIV_W'(TOT_W'(tot - TOT_W'(1)));
            end
            OP_DIV_H:
            begin
                div_start = 1'b1;
                wide      = WIDE_W'(hp) << 1;
                div_den   = DIV_W'(tot);
            end
            OP_DIV_FST:
            begin
                div_start = 1'b1;
                wide      = frac_num(n_reg);
                div_den   = d_reg;
            end
            OP_DIV_AVG:
            begin
                div_start = 1'b1;
                wide      = WIDE_W'(avg_num);
                div_den   = DIV_W'(count_reg);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
        div_hi = wide[WIDE_W-1:Q_W];
        div_lo = wide[Q_W-1:0];
    end

    afs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .hi    (div_hi),
        .lo    (div_lo),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_q)
    );

    always_comb
    begin
        qinc = {1'b0, div_q} + (Q_W+1)'(1);
        qr   = qinc[FREQ_W:1];
        if (sum_sel[SUM_W-1])
        begin
            if (ovf_reg || (div_q[Q_W-1] && (div_q[Q_W-2:0] != '0)))
                avg_val = VMIN;
            else
                avg_val = signed'(VAL_W'(-div_q));
        end
        else
        begin
            if (ovf_reg || div_q[Q_W-1])
                avg_val = VMAX;
            else
                avg_val = signed'(VAL_W'(div_q));
        end
    end

    assign out_free = !out_valid_reg || out_ready;
    assign out_load = out_free && ((cmd.op == OP_OUT_LOC) || (cmd.op == OP_OUT_AVG));

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD)
        begin
            anc1_reg <= in_data[IN_W +: COUNT_BITS] > in_data[0 +: COUNT_BITS];
            last_reg <= in_last;
            for (int k = 0; k < NUM_POPS; k++)
            begin
                pa0_reg[k] <= in_data[(2*k+2)*IN_W +: COUNT_BITS];
                pa1_reg[k] <= in_data[(2*k+3)*IN_W +: COUNT_BITS];
            end
        end
        if (div_start)
        begin
            dst_reg <= cmd.op;
            ovf_reg <= div_hi >= div_den;
        end
        if (div_done)
        begin
            case (dst_reg)
                OP_DIV_F0:  f0_reg[cmd.idx] <= (tot == '0) ? '0 : qr;
                OP_DIV_F1:  f1_reg[cmd.idx] <= (tot == '0) ? '0 : qr;
                OP_DIV_A1:  a1r_reg <= qr;
                OP_DIV_H:   h_reg[cmd.idx] <= hzero ? '0 : qr;
                OP_DIV_FST: fst_reg <= (d_reg == '0) ? '0 : signed'(VAL_W'(qr));
                OP_DIV_AVG: avg_reg[cmd.idx] <= avg_val;
                default:    a1r_reg <= a1r_reg;
            endcase
        end
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        prod_reg <= ma_reg * mb_reg;
        case (cmd.op)
            OP_F2: f2_reg <= rnd_sat(prod_reg - hshift(h_reg[0]) - hshift(h_reg[1]));
            OP_F3: f3_reg <= rnd_sat(prod_reg - hshift(h_reg[2]));
            OP_F4: f4_reg <= rnd_sat(prod_reg);
            OP_N:  n_reg  <= prod_reg[DIV_W-1:0];
            OP_D1: d_reg  <= prod_reg[DIV_W-1:0];
            OP_D2: d_reg  <= d_reg + prod_reg[DIV_W-1:0];
            default: n_reg <= n_reg;
        endcase
        if (out_load)
        begin
            if (cmd.op == OP_OUT_AVG)
            begin
                out_data_reg <= {VAL_W'(0), avg_reg[2], avg_reg[1], avg_reg[0]};
                out_kind_reg <= 1'b1;
                out_last_reg <= 1'b1;
            end
            else
            begin
                out_data_reg <= {fst_reg, f4_reg, f3_reg, f2_reg};
                out_kind_reg <= 1'b0;
                out_last_reg <= !last_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            for (int k = 0; k < 3; k++)
            begin
                sum_reg[k] <= '0;
            end
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (cmd.op == OP_ACC)
            begin
                sum_reg[0] <= sat_add(sum_reg[0], f2_reg);
                sum_reg[1] <= sat_add(sum_reg[1], f3_reg);
                sum_reg[2] <= sat_add(sum_reg[2], f4_reg);
                if (count_reg != '1)
                    count_reg <= count_reg + 1'b1;
            end
            else if (out_load && (cmd.op == OP_OUT_AVG))
            begin
                count_reg <= '0;
                for (int k = 0; k < 3; k++)
                begin
                    sum_reg[k] <= '0;
                end
            end
        end
    end

    assign stat.div_done = div_done;
    assign stat.out_free = out_free;
    assign stat.last     = last_reg;
    assign out_valid     = out_valid_reg;
    assign out_data      = out_data_reg;
    assign out_kind      = out_kind_reg;
    assign out_last      = out_last_reg;

endmodule

// ===== sv/afs_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afs_ctrl
// Sequencer for one locus: four divisions per population, the statistic
// products, Fst division, accumulation, output and the closing averages.
// ----------------------------------------------------------------------------
module afs_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  afs_pkg::stat_t stat,
    output afs_pkg::cmd_t  cmd
);

    import afs_pkg::*;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_DF0  = 5'd1;
    localparam logic [4:0] S_DF1  = 5'd2;
    localparam logic [4:0] S_DA1  = 5'd3;
    localparam logic [4:0] S_MH   = 5'd4;
    localparam logic [4:0] S_DH   = 5'd5;
    localparam logic [4:0] S_NP   = 5'd6;
    localparam logic [4:0] S_WDIV = 5'd7;
    localparam logic [4:0] S_WMUL = 5'd8;
    localparam logic [4:0] S_MX   = 5'd9;
    localparam logic [4:0] S_F2   = 5'd10;
    localparam logic [4:0] S_MF3  = 5'd11;
    localparam logic [4:0] S_F3   = 5'd12;
    localparam logic [4:0] S_MF4  = 5'd13;
    localparam logic [4:0] S_F4   = 5'd14;
    localparam logic [4:0] S_MN   = 5'd15;
    localparam logic [4:0] S_N    = 5'd16;
    localparam logic [4:0] S_MD1  = 5'd17;
    localparam logic [4:0] S_D1   = 5'd18;
    localparam logic [4:0] S_MD2  = 5'd19;
    localparam logic [4:0] S_D2   = 5'd20;
    localparam logic [4:0] S_DFST = 5'd21;
    localparam logic [4:0] S_ACC  = 5'd22;
    localparam logic [4:0] S_OLOC = 5'd23;
    localparam logic [4:0] S_DAVG = 5'd24;
    localparam logic [4:0] S_NAVG = 5'd25;
    localparam logic [4:0] S_OAVG = 5'd26;

    logic [4:0]       state_reg;
    logic [4:0]       state_next;
    logic [4:0]       ret_reg;
    logic [4:0]       ret_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;

    always_comb
    begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        idx_next    = idx_reg;
        cmd.op      = OP_NONE;
        cmd.mul_sel = MS_H;
        cmd.idx     = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    idx_next   = '0;
                    state_next = S_DF0;
                end
            end
            S_DF0:
            begin
                cmd.op     = OP_DIV_F0;
                ret_next   = S_DF1;
                state_next = S_WDIV;
            end
            S_DF1:
            begin
                cmd.op     = OP_DIV_F1;
                ret_next   = S_DA1;
                state_next = S_WDIV;
            end
            S_DA1:
            begin
                cmd.op     = OP_DIV_A1;
                ret_next   = S_MH;
                state_next = S_WDIV;
            end
            S_MH:
            begin
                cmd.op      = OP_MUL;
                cmd.mul_sel = MS_H;
                ret_next    = S_DH;
                state_next  = S_WMUL;
            end
            S_DH:
            begin
                cmd.op     = OP_DIV_H;
                ret_next   = S_NP;
                state_next = S_WDIV;
            end
            S_NP:
            begin
                if (idx_reg == IDX_W'(NUM_POPS - 1))
                    state_next = S_MX;
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_DF0;
                end
            end
            S_WDIV:
            begin
                if (stat.div_done)
                    state_next = ret_reg;
            end
            S_WMUL:
            begin
                state_next = ret_reg;
            end
            S_MX:
            begin
                cmd.op      = OP_MUL;
                cmd.mul_sel = MS_X2;
                ret_next    = S_F2;
                state_next  = S_WMUL;
            end
            S_F2:
            begin
                cmd.op     = OP_F2;
                state_next = S_MF3;
            end
            S_MF3:
            begin
                cmd.op      = OP_MUL;
                cmd.mul_sel = MS_F3;
                ret_next    = S_F3;
                state_next  = S_WMUL;
            end
            S_F3:
            begin
                cmd.op     = OP_F3;
                state_next = S_MF4;
            end
            S_MF4:
            begin
                cmd.op      = OP_MUL;
                cmd.mul_sel = MS_F4;
                ret_next    = S_F4;
                state_next  = S_WMUL;
            end
            S_F4:
            begin
                cmd.op     = OP_F4;
                state_next = S_MN;
            end
            S_MN:
            begin
                cmd.op      = OP_MUL;
                cmd.mul_sel = MS_N;
                ret_next    = S_N;
                state_next  = S_WMUL;
            end
            S_N:
            begin
                cmd.op     = OP_N;
                state_next = S_MD1;
            end
            S_MD1:
            begin
                cmd.op      = OP_MUL;
                cmd.mul_sel = MS_D1;
                ret_next    = S_D1;
                state_next  = S_WMUL;
            end
            S_D1:
            begin
                cmd.op     = OP_D1;
                state_next = S_MD2;
            end
            S_MD2:
            begin
                cmd.op      = OP_MUL;
                cmd.mul_sel = MS_D2;
                ret_next    = S_D2;
                state_next  = S_WMUL;
            end
            S_D2:
            begin
                cmd.op     = OP_D2;
                state_next = S_DFST;
            end
            S_DFST:
            begin
                cmd.op     = OP_DIV_FST;
                ret_next   = S_ACC;
                state_next = S_WDIV;
            end
            S_ACC:
            begin
                cmd.op     = OP_ACC;
                state_next = S_OLOC;
            end
            S_OLOC:
            begin
                cmd.op = OP_OUT_LOC;
                if (stat.out_free)
                begin
                    idx_next   = '0;
                    state_next = stat.last ? S_DAVG : S_IDLE;
                end
            end
            S_DAVG:
            begin
                cmd.op     = OP_DIV_AVG;
                ret_next   = S_NAVG;
                state_next = S_WDIV;
            end
            S_NAVG:
            begin
                if (idx_reg == IDX_W'(2))
                    state_next = S_OAVG;
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_DAVG;
                end
            end
            S_OAVG:
            begin
                cmd.op = OP_OUT_AVG;
                if (stat.out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            idx_reg   <= idx_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

// ===== sv/allele_fstat_accumulator.sv =====
`timescale 1ns / 1ps
// Each accepted locus takes 17 passes of the shared bit-serial divider before
// its per-locus result is loaded; a new locus is accepted only once the block
// is idle again, and a final locus adds three average divisions. Output stalls
// delay both the result and the next accept.
// Reset: sums and locus count clear, no result pending, input ready.
// ----------------------------------------------------------------------------
// allele_fstat_accumulator
// Per-locus f2, f3, f4 and Fst with running sums and averages at data set end.
// ----------------------------------------------------------------------------
module allele_fstat_accumulator
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // out_allele0, out_allele1, pop_a_allele0, pop_a_allele1, pop_b_allele0,
    // pop_b_allele1, pop_c_allele0, pop_c_allele1, pop_d_allele0, pop_d_allele1
    input  logic [afs_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                           s_axis_tlast,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // f2_value, f3_value, f4_value, fst_value
    output logic [afs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // result_kind
    output logic                           m_axis_tuser,
    output logic                           m_axis_tlast
);

    import afs_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    afs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    afs_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_kind  (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

endmodule

// ===== verif/fstat_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fstat_checker
// Watches both streams of the f-statistics accumulator, predicts per-locus
// f2/f3/f4/Fst and data set averages, and compares every output transaction.
// ----------------------------------------------------------------------------
module fstat_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic [afs_pkg::IN_DATA_W-1:0]  s_data,
    input  logic                           s_last,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [afs_pkg::OUT_DATA_W-1:0] m_data,
    input  logic                           m_user,
    input  logic                           m_last,
    output int                             fail_count,
    output int                             pending,
    output int                             loci_seen,
    output int                             sets_seen
);

    import afs_pkg::*;

    typedef struct {
        logic        kind;
        logic [31:0] f2;
        logic [31:0] f3;
        logic [31:0] f4;
        logic [31:0] fst;
        logic        last;
    } stat_result_t;

    localparam longint ONE = 64'sd1 << FRAC_BITS;
    localparam longint SUM_MAX = (64'sd1 << 55) - 1;
    localparam longint SUM_MIN = -SUM_MAX - 1;
    localparam longint CNT_MAX = (64'sd1 << LOCUS_BITS) - 1;

    stat_result_t expected_q[$];
    longint f2_acc, f3_acc, f4_acc, loci_acc;

    function automatic longint unsigned round_div(longint unsigned n, longint unsigned d,
                                                  int frac);
        longint unsigned q, r, r2;
        q = n / d;
        r = n % d;
        for (int i = 0; i <= frac; i++) begin
            r2 = r << 1;
            q = q << 1;
            if (r2 >= d) begin
                q = q | 1;
                r2 = r2 - d;
            end
            r = r2;
        end
        return (q + 1) >> 1;
    endfunction

    function automatic longint round_frac(longint v);
        longint w;
        longint unsigned m;
        w = v + (64'sd1 << (FRAC_BITS - 1));
        if (w >= 0)
            return longint'(longint'(unsigned'(w)) >>> 0) >>> FRAC_BITS;
        m = longint'(-w);
        return -longint'((m + (ONE - 1)) >> FRAC_BITS);
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint clip_sum(longint s, longint v);
        longint r;
        r = s + v;
        if (r > SUM_MAX)
            return SUM_MAX;
        if (r < SUM_MIN)
            return SUM_MIN;
        return r;
    endfunction

    function automatic longint mean(longint s, longint n);
        longint unsigned mag, q;
        mag = (s < 0) ? longint'(-s) : s;
        if (n == 0)
            return 0;
        q = (mag + n / 2) / n;
        return clip32((s < 0) ? -longint'(q) : longint'(q));
    endfunction

    function automatic longint unsigned allele_freq(longint unsigned c, longint unsigned t);
        return (t == 0) ? 0 : round_div(c, t, FRAC_BITS);
    endfunction

    function automatic longint het_term(longint unsigned c0, longint unsigned c1);
        longint unsigned t, a0, a1, h;
        t = c0 + c1;
        if (t < 2 || c0 == 0 || c1 == 0)
            return 0;
        a0 = round_div(c0, t, FRAC_BITS);
        a1 = round_div(c1, t - 1, FRAC_BITS);
        h = (a0 * a1 + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return round_div(h, t, 0);
    endfunction

    task automatic predict_locus(logic [IN_DATA_W-1:0] data, logic final_locus);
        longint unsigned cnt[10];
        longint unsigned anc[4], der[4], n, d, t;
        longint het[4];
        longint x, f2, f3, f4, fst;
        longint m2, m3, m4;
        logic anc_is1;
        stat_result_t r;
        for (int i = 0; i < 10; i++)
            cnt[i] = data[i*IN_W +: IN_W] & ((64'd1 << COUNT_BITS) - 1);
        anc_is1 = cnt[1] > cnt[0];
        for (int i = 0; i < 4; i++) begin
            t = cnt[2+2*i] + cnt[3+2*i];
            anc[i] = allele_freq(anc_is1 ? cnt[3+2*i] : cnt[2+2*i], t);
            der[i] = allele_freq(anc_is1 ? cnt[2+2*i] : cnt[3+2*i], t);
            het[i] = het_term(cnt[2+2*i], cnt[3+2*i]);
        end
        x = longint'(anc[0]) - longint'(anc[1]);
        f2 = clip32(round_frac(x * x - (het[0] <<< FRAC_BITS) - (het[1] <<< FRAC_BITS)));
        f3 = clip32(round_frac((longint'(anc[2]) - longint'(anc[0])) *
                               (longint'(anc[2]) - longint'(anc[1])) -
                               (het[2] <<< FRAC_BITS)));
        f4 = clip32(round_frac(x * (longint'(anc[2]) - longint'(anc[3]))));
        x = longint'(der[0]) - longint'(der[1]);
        n = x * x;
        d = der[0] * (ONE - der[1]) + der[1] * (ONE - der[0]);
        fst = (d == 0) ? 0 : clip32(longint'(round_div(n, d, FRAC_BITS)));
        f2_acc = clip_sum(f2_acc, f2);
        f3_acc = clip_sum(f3_acc, f3);
        f4_acc = clip_sum(f4_acc, f4);
        if (loci_acc < CNT_MAX)
            loci_acc++;
        r.kind = 1'b0;
        r.f2 = f2[31:0];
        r.f3 = f3[31:0];
        r.f4 = f4[31:0];
        r.fst = fst[31:0];
        r.last = !final_locus;
        expected_q = {expected_q, r};
        if (final_locus) begin
            m2 = mean(f2_acc, loci_acc);
            m3 = mean(f3_acc, loci_acc);
            m4 = mean(f4_acc, loci_acc);
            r.kind = 1'b1;
            r.f2 = m2[31:0];
            r.f3 = m3[31:0];
            r.f4 = m4[31:0];
            r.fst = '0;
            r.last = 1'b1;
            expected_q = {expected_q, r};
            f2_acc = 0;
            f3_acc = 0;
            f4_acc = 0;
            loci_acc = 0;
        end
    endtask

    task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    initial
    begin
        fail_count = 0;
        loci_seen = 0;
        sets_seen = 0;
        f2_acc = 0;
        f3_acc = 0;
        f4_acc = 0;
        loci_acc = 0;
    end

    assign pending = expected_q.size();

    always @(posedge clk)
    begin
        stat_result_t e;
        if (rst_n) begin
            if (s_valid && s_ready) begin
                predict_locus(s_data, s_last);
                loci_seen++;
                if (s_last)
                    sets_seen++;
            end
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected output transaction");
                    fail_count++;
                end else begin
                    e = expected_q.pop_front();
                    compare_field("result_kind", 32'(e.kind), 32'(m_user));
                    compare_field("f2_value", e.f2, m_data[31:0]);
                    compare_field("f3_value", e.f3, m_data[63:32]);
                    compare_field("f4_value", e.f4, m_data[95:64]);
                    compare_field("fst_value", e.fst, m_data[127:96]);
                    compare_field("last_result", 32'(e.last), 32'(m_last));
                end
            end
        end
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives loci into the f-statistics accumulator under varying idle and stall
// patterns; the checker predicts and compares every output transaction.
// ----------------------------------------------------------------------------
module tb;
    import afs_pkg::*;

    localparam int RANDOM_LOCI = 1550;
    localparam longint CYCLE_LIMIT = 64'd6000000;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;
    int                    fail_count;
    int                    pending;
    int                    loci_seen;
    int                    sets_seen;
    int                    send_idle_pct;
    int                    recv_idle_pct;
    longint                cycle_count;

    allele_fstat_accumulator i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    fstat_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_data     (s_axis_tdata),
        .s_last     (s_axis_tlast),
        .m_valid    (m_axis_tvalid),
        .m_ready    (m_axis_tready),
        .m_data     (m_axis_tdata),
        .m_user     (m_axis_tuser),
        .m_last     (m_axis_tlast),
        .fail_count (fail_count),
        .pending    (pending),
        .loci_seen  (loci_seen),
        .sets_seen  (sets_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycle_count);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic [15:0] rand_count();
        case ($urandom_range(5))
            0: return 16'd0;
            1: return 16'($urandom_range(3));
            2: return 16'hFFFF - 16'($urandom_range(3));
            3: return 16'($urandom_range(255));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_locus(logic [IN_DATA_W-1:0] data, logic final_locus);
        while ($urandom_range(99) < send_idle_pct)
            @(posedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tlast  <= final_locus;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_counts(logic [15:0] c[10], logic final_locus);
        logic [IN_DATA_W-1:0] d;
        for (int i = 0; i < 10; i++)
            d[i*16 +: 16] = c[i];
        send_locus(d, final_locus);
    endtask

    initial
    begin
        logic [15:0] c[10];
        logic [IN_DATA_W-1:0] d;
        int set_len;
        int left;
        int sent;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty, extremes, ties, single copies, monomorphic
        foreach (c[i]) c[i] = 16'd0;
        send_counts(c, 1'b0);
        foreach (c[i]) c[i] = 16'hFFFF;
        send_counts(c, 1'b0);
        c = '{16'd5, 16'd5, 16'd1, 16'd0, 16'd0, 16'd1, 16'd1, 16'd1, 16'd0, 16'd0};
        send_counts(c, 1'b0);
        c = '{16'd0, 16'd9, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'd3, 16'd7, 16'd2, 16'd2};
        send_counts(c, 1'b0);
        c = '{16'd9, 16'd0, 16'd10, 16'd10, 16'd10, 16'd10, 16'd0, 16'd0, 16'd1, 16'd0};
        send_counts(c, 1'b0);
        c = '{16'd3, 16'd4, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF};
        send_counts(c, 1'b1);
        c = '{16'd1, 16'd0, 16'd2, 16'd1, 16'd1, 16'd2, 16'd1, 16'd1, 16'd4, 16'd0};
        send_counts(c, 1'b1);
        for (int k = 0; k < 6; k++) begin
            foreach (c[i]) c[i] = rand_count();
            send_counts(c, k == 5);
        end
        // hold off until drained
        wait (pending == 0);
        @(posedge clk);

        left = RANDOM_LOCI;
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 64 : 0;
            recv_idle_pct = (phase == 0) ? 64 : (phase == 1) ? 32 : 0;
            sent = 0;
            while (sent < RANDOM_LOCI / 3 && left > 0) begin
                if ($urandom_range(9) == 0) begin
                    d = {$urandom, $urandom, $urandom, $urandom, $urandom};
                    send_locus(d, 1'($urandom_range(1)));
                    left--;
                    sent++;
                end else begin
                    set_len = $urandom_range(12, 1);
                    for (int j = 0; j < set_len && left > 0; j++) begin
                        foreach (c[i]) c[i] = rand_count();
                        send_counts(c, j == set_len - 1);
                        left--;
                        sent++;
                    end
                end
            end
        end
        send_counts(c, 1'b1);

        wait (pending == 0);
        repeat (800) @(posedge clk);
        $display("Covered %0d loci in %0d data sets, with empty, tied and saturated counts",
                 loci_seen, sets_seen);
        $display("under three sender/receiver idle mixes and a full drain pause.");
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== allele_fstat_accumulator.f =====
sv/afs_pkg.sv
sv/afs_div.sv
sv/afs_datapath.sv
sv/afs_ctrl.sv
sv/allele_fstat_accumulator.sv
verif/fstat_checker.sv
verif/tb.sv
